>>> rtl/core/slbc_pkg.sv
// ----------------------------------------------------------------------------
// slbc_pkg
// Shared types, codes and helpers for the status LED blink controller.
// ----------------------------------------------------------------------------
package slbc_pkg;

    // Number of profile indicators and width of the millisecond countdowns
    localparam int PROFILE_COUNT = 3;
    localparam int TIMER_BITS    = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int LED_W       = 3;

    typedef logic [TIMER_BITS-1:0] timer_t;
    typedef logic [LED_W-1:0]      led_mask_t;
    typedef logic [1:0]            slot_t;

    localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

    // Operation codes
    localparam logic [2:0] OP_TICK             = 3'd0;
    localparam logic [2:0] OP_KEY              = 3'd1;
    localparam logic [2:0] OP_USB_CHANGE       = 3'd2;
    localparam logic [2:0] OP_PROFILE_CMD      = 3'd3;
    localparam logic [2:0] OP_PROFILE_CHANGED  = 3'd4;
    localparam logic [2:0] OP_ENDPOINT_CHANGED = 3'd5;

    // Key kinds
    localparam logic [1:0] KEY_MUTE    = 2'd1;
    localparam logic [1:0] KEY_MICMUTE = 2'd2;

    // Profile command kinds
    localparam logic [1:0] CMD_USB    = 2'd0;
    localparam logic [1:0] CMD_SELECT = 2'd1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PROFILE_IDENTIFY = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_USB_IDENTIFY     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PAIRING_BLINK    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RECONNECT_ON     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RECONNECT_OFF    = 3'd4;

    // Configuration reset values
    localparam logic [CFG_DATA_W-1:0] RST_PROFILE_IDENTIFY = 16'd5000;
    localparam logic [CFG_DATA_W-1:0] RST_USB_IDENTIFY     = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] RST_PAIRING_BLINK    = 16'd150;
    localparam logic [CFG_DATA_W-1:0] RST_RECONNECT_ON     = 16'd120;
    localparam logic [CFG_DATA_W-1:0] RST_RECONNECT_OFF    = 16'd1880;

    // Power LED rhythms
    localparam timer_t USB_WAIT_ON_MS  = TIMER_BITS'(120);
    localparam timer_t USB_WAIT_OFF_MS = TIMER_BITS'(880);
    localparam timer_t OPEN_HALF_MS    = TIMER_BITS'(150);
    localparam timer_t BONDED_ON_MS    = TIMER_BITS'(200);
    localparam timer_t BONDED_OFF_MS   = TIMER_BITS'(800);

    localparam slot_t SLOT_NONE = 2'd3;

    // Input item as held in the input register
    typedef struct packed {
        logic [2:0] operation;
        logic       usb_hid_ready;
        logic       active_connected;
        logic       active_open;
        logic [1:0] active_profile;
        logic [1:0] key_kind;
        logic [1:0] command_kind;
        logic       command_ble;
        logic [1:0] command_profile;
        logic       command_profile_open;
        logic       endpoint_ble;
    } evt_item_t;

    // Saturate a 16-bit duration to the countdown range
    function automatic timer_t clamp_ms(logic [CFG_DATA_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w > TIMER_MAX)
        begin
            w = TIMER_MAX;
        end
        return w[TIMER_BITS-1:0];
    endfunction

    // LED bit for a profile index; no bit for the none slot or a missing LED
    function automatic led_mask_t led_bit(slot_t idx);
        led_mask_t m;
        m = '0;
        if (idx != SLOT_NONE && 32'(idx) < PROFILE_COUNT)
        begin
            m = led_mask_t'(1) << idx;
        end
        return m;
    endfunction

    // Every profile LED that exists
    function automatic led_mask_t all_leds();
        led_mask_t m;
        m = '0;
        for (int i = 0; i < LED_W; i++)
        begin
            m = m | led_bit(slot_t'(i));
        end
        return m;
    endfunction

endpackage

>>> rtl/core/slbc_if.sv
// ----------------------------------------------------------------------------
// slbc_if
// Valid/ready channels of the status LED blink controller.
// ----------------------------------------------------------------------------

// Event and tick items with the current link status
interface slbc_evt_if ();
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic       usb_hid_ready;
    logic       active_connected;
    logic       active_open;
    logic [1:0] active_profile;
    logic [1:0] key_kind;
    logic [1:0] command_kind;
    logic       command_ble;
    logic [1:0] command_profile;
    logic       command_profile_open;
    logic       endpoint_ble;

    modport source (
        output valid, operation, usb_hid_ready, active_connected, active_open,
               active_profile, key_kind, command_kind, command_ble,
               command_profile, command_profile_open, endpoint_ble,
        input  ready
    );
    modport sink (
        input  valid, operation, usb_hid_ready, active_connected, active_open,
               active_profile, key_kind, command_kind, command_ble,
               command_profile, command_profile_open, endpoint_ble,
        output ready
    );
endinterface

// LED levels after each item
interface slbc_led_if ();
    logic       valid;
    logic       ready;
    logic       power_ind;
    logic       mute_ind;
    logic       mic_mute_ind;
    logic [2:0] profile_ind;

    modport source (
        output valid, power_ind, mute_ind, mic_mute_ind, profile_ind,
        input  ready
    );
    modport sink (
        input  valid, power_ind, mute_ind, mic_mute_ind, profile_ind,
        output ready
    );
endinterface

// Register writes
interface slbc_cfg_if ();
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/status_led_blink_controller.sv
// ----------------------------------------------------------------------------
// status_led_blink_controller
// Power, mute, mic-mute and profile indicator sequencing from 1 ms ticks
// and link events.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | accepted when
//  --------+-----+------------------------------------------+----------------
//  evt     | in  | operation, link status, key/command info | valid && ready
//  led     | out | power, mute, mic mute, profile mask      | valid && ready
//  cfg     | in  | index, data (five 16-bit durations)      | valid && ready
//
//  One item per cycle sustained while results are taken; a result passes the
//  input register, then the state update into the result register.
//  Reset loads the default durations and leaves the power timer due, so the
//  first item already sets the power LED.
//  A stalled result holds the result register; the input register still
//  takes an item, and the input side stalls only when both are full.
//  Register writes are always taken.
// ----------------------------------------------------------------------------
module status_led_blink_controller
    import slbc_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    slbc_evt_if.sink       evt,
    slbc_led_if.source     led,
    slbc_cfg_if.sink       cfg
);

    // Configuration registers
    logic [CFG_DATA_W-1:0] profile_identify_ms_reg;
    logic [CFG_DATA_W-1:0] usb_identify_ms_reg;
    logic [CFG_DATA_W-1:0] pairing_blink_ms_reg;
    logic [CFG_DATA_W-1:0] reconnect_on_ms_reg;
    logic [CFG_DATA_W-1:0] reconnect_off_ms_reg;

    // Pipeline control and payload
    logic      in_valid_reg, in_valid_next;
    evt_item_t in_item_reg;
    evt_item_t evt_item;
    logic      out_valid_reg, out_valid_next;
    logic      advance;

    // Indicator state
    logic      requested_ble_reg,     requested_ble_next;
    logic      power_phase_reg,       power_phase_next;
    timer_t    power_countdown_reg,   power_countdown_next;
    logic      power_armed_reg,       power_armed_next;
    logic      power_level_reg,       power_level_next;
    logic      profile_phase_reg,     profile_phase_next;
    logic      usb_identifying_reg,   usb_identifying_next;
    timer_t    identify_left_reg,     identify_left_next;
    slot_t     identify_slot_reg,     identify_slot_next;
    timer_t    profile_countdown_reg, profile_countdown_next;
    logic      profile_armed_reg,     profile_armed_next;
    led_mask_t profile_mask_reg,      profile_mask_next;
    logic      mute_level_reg,        mute_level_next;
    logic      micmute_level_reg,     micmute_level_next;

    // Gather the incoming item
    assign evt_item = '{
        operation:            evt.operation,
        usb_hid_ready:        evt.usb_hid_ready,
        active_connected:     evt.active_connected,
        active_open:          evt.active_open,
        active_profile:       evt.active_profile,
        key_kind:             evt.key_kind,
        command_kind:         evt.command_kind,
        command_ble:          evt.command_ble,
        command_profile:      evt.command_profile,
        command_profile_open: evt.command_profile_open,
        endpoint_ble:         evt.endpoint_ble
    };

    // Move the held item into the result register when it is free
    assign advance   = in_valid_reg && (!out_valid_reg || led.ready);
    assign evt.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (evt.valid && evt.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (led.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Apply the item, then run whichever timer handler is due
    always_comb
    begin
        requested_ble_next     = requested_ble_reg;
        power_phase_next       = power_phase_reg;
        power_countdown_next   = power_countdown_reg;
        power_armed_next       = power_armed_reg;
        power_level_next       = power_level_reg;
        profile_phase_next     = profile_phase_reg;
        usb_identifying_next   = usb_identifying_reg;
        identify_left_next     = identify_left_reg;
        identify_slot_next     = identify_slot_reg;
        profile_countdown_next = profile_countdown_reg;
        profile_armed_next     = profile_armed_reg;
        profile_mask_next      = profile_mask_reg;
        mute_level_next        = mute_level_reg;
        micmute_level_next     = micmute_level_reg;

        unique case (in_item_reg.operation)
            OP_TICK:
            begin
                if (power_armed_reg && power_countdown_reg != '0)
                begin
                    power_countdown_next = power_countdown_reg - timer_t'(1);
                end
                if (profile_armed_reg && profile_countdown_reg != '0)
                begin
                    profile_countdown_next = profile_countdown_reg - timer_t'(1);
                end
                if (identify_left_reg != '0)
                begin
                    identify_left_next = identify_left_reg - timer_t'(1);
                end
            end
            OP_KEY:
            begin
                if (in_item_reg.key_kind == KEY_MUTE)
                begin
                    mute_level_next = !mute_level_reg;
                end
                else if (in_item_reg.key_kind == KEY_MICMUTE)
                begin
                    micmute_level_next = !micmute_level_reg;
                end
            end
            OP_USB_CHANGE:
            begin
                power_phase_next     = 1'b0;
                power_armed_next     = 1'b1;
                power_countdown_next = '0;
            end
            OP_PROFILE_CMD:
            begin
                requested_ble_next   = in_item_reg.command_ble;
                power_phase_next     = 1'b0;
                power_armed_next     = 1'b1;
                power_countdown_next = '0;
                profile_phase_next   = 1'b0;
                if (in_item_reg.command_kind == CMD_USB)
                begin
                    usb_identifying_next = 1'b1;
                    requested_ble_next   = 1'b0;
                    identify_slot_next   = SLOT_NONE;
                    identify_left_next   = clamp_ms(usb_identify_ms_reg);
                end
                else
                begin
                    usb_identifying_next = 1'b0;
                    identify_slot_next   = in_item_reg.command_profile;
                    if (in_item_reg.command_kind == CMD_SELECT
                        && !in_item_reg.command_profile_open)
                    begin
                        identify_left_next = clamp_ms(profile_identify_ms_reg);
                    end
                    else
                    begin
                        identify_left_next = '0;
                    end
                end
                profile_armed_next     = 1'b1;
                profile_countdown_next = '0;
            end
            OP_PROFILE_CHANGED:
            begin
                power_phase_next       = 1'b0;
                power_armed_next       = 1'b1;
                power_countdown_next   = '0;
                profile_phase_next     = 1'b0;
                usb_identifying_next   = 1'b0;
                identify_left_next     = '0;
                identify_slot_next     = SLOT_NONE;
                profile_armed_next     = 1'b1;
                profile_countdown_next = '0;
            end
            OP_ENDPOINT_CHANGED:
            begin
                power_phase_next     = 1'b0;
                power_armed_next     = 1'b1;
                power_countdown_next = '0;
                if (in_item_reg.endpoint_ble)
                begin
                    profile_phase_next     = 1'b0;
                    usb_identifying_next   = 1'b0;
                    identify_left_next     = clamp_ms(profile_identify_ms_reg);
                    identify_slot_next     = in_item_reg.active_profile;
                    profile_armed_next     = 1'b1;
                    profile_countdown_next = '0;
                end
            end
            default:
            begin
            end
        endcase

        // Power timer expiry: steady on when the link is up, else blink
        if (power_armed_next && power_countdown_next == '0)
        begin
            power_armed_next = 1'b0;
            if ((!requested_ble_next && in_item_reg.usb_hid_ready)
                || (requested_ble_next && in_item_reg.active_connected))
            begin
                power_level_next = 1'b1;
                power_phase_next = 1'b1;
            end
            else
            begin
                power_phase_next = !power_phase_next;
                power_level_next = power_phase_next;
                power_armed_next = 1'b1;
                if (!requested_ble_next)
                begin
                    power_countdown_next = power_phase_next ? USB_WAIT_ON_MS
                                                            : USB_WAIT_OFF_MS;
                end
                else if (in_item_reg.active_open)
                begin
                    power_countdown_next = OPEN_HALF_MS;
                end
                else
                begin
                    power_countdown_next = power_phase_next ? BONDED_ON_MS
                                                            : BONDED_OFF_MS;
                end
            end
        end

        // Profile timer expiry: identification first, then pairing/reconnect blink
        if (profile_armed_next && profile_countdown_next == '0)
        begin
            profile_armed_next = 1'b0;
            if (identify_left_next != '0)
            begin
                if (!requested_ble_next && usb_identifying_next)
                begin
                    profile_mask_next = all_leds();
                end
                else
                begin
                    profile_mask_next = led_bit(identify_slot_next);
                end
                profile_armed_next     = 1'b1;
                profile_countdown_next = identify_left_next;
            end
            else if (!requested_ble_next || in_item_reg.active_connected)
            begin
                profile_mask_next = '0;
            end
            else
            begin
                profile_phase_next = !profile_phase_next;
                profile_mask_next  = profile_phase_next
                                     ? led_bit(in_item_reg.active_profile) : '0;
                profile_armed_next = 1'b1;
                if (in_item_reg.active_open)
                begin
                    profile_countdown_next = clamp_ms(pairing_blink_ms_reg);
                end
                else if (profile_phase_next)
                begin
                    profile_countdown_next = clamp_ms(reconnect_on_ms_reg);
                end
                else
                begin
                    profile_countdown_next = clamp_ms(reconnect_off_ms_reg);
                end
            end
        end
    end

    // Hold control, state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            profile_identify_ms_reg <= RST_PROFILE_IDENTIFY;
            usb_identify_ms_reg     <= RST_USB_IDENTIFY;
            pairing_blink_ms_reg    <= RST_PAIRING_BLINK;
            reconnect_on_ms_reg     <= RST_RECONNECT_ON;
            reconnect_off_ms_reg    <= RST_RECONNECT_OFF;
            requested_ble_reg       <= 1'b0;
            power_phase_reg         <= 1'b0;
            power_countdown_reg     <= '0;
            power_armed_reg         <= 1'b1;
            power_level_reg         <= 1'b0;
            profile_phase_reg       <= 1'b0;
            usb_identifying_reg     <= 1'b0;
            identify_left_reg       <= '0;
            identify_slot_reg       <= SLOT_NONE;
            profile_countdown_reg   <= '0;
            profile_armed_reg       <= 1'b0;
            profile_mask_reg        <= '0;
            mute_level_reg          <= 1'b0;
            micmute_level_reg       <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;

            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_PROFILE_IDENTIFY: profile_identify_ms_reg <= cfg.data;
                    REG_USB_IDENTIFY:     usb_identify_ms_reg     <= cfg.data;
                    REG_PAIRING_BLINK:    pairing_blink_ms_reg    <= cfg.data;
                    REG_RECONNECT_ON:     reconnect_on_ms_reg     <= cfg.data;
                    REG_RECONNECT_OFF:    reconnect_off_ms_reg    <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end

            if (advance)
            begin
                requested_ble_reg     <= requested_ble_next;
                power_phase_reg       <= power_phase_next;
                power_countdown_reg   <= power_countdown_next;
                power_armed_reg       <= power_armed_next;
                power_level_reg       <= power_level_next;
                profile_phase_reg     <= profile_phase_next;
                usb_identifying_reg   <= usb_identifying_next;
                identify_left_reg     <= identify_left_next;
                identify_slot_reg     <= identify_slot_next;
                profile_countdown_reg <= profile_countdown_next;
                profile_armed_reg     <= profile_armed_next;
                profile_mask_reg      <= profile_mask_next;
                mute_level_reg        <= mute_level_next;
                micmute_level_reg     <= micmute_level_next;
            end
        end
    end

    // Capture the input item
    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            in_item_reg <= evt_item;
        end
    end

    // Drive the result from the state registers
    assign led.valid        = out_valid_reg;
    assign led.power_ind    = power_level_reg;
    assign led.mute_ind     = mute_level_reg;
    assign led.mic_mute_ind = micmute_level_reg;
    assign led.profile_ind  = profile_mask_reg;

`ifndef NO_ASSERTIONS
    // The power level always follows the blink phase
    a_power_phase: assert property (@(posedge clk) disable iff (!rst_n)
        power_level_reg == power_phase_reg)
        else $error("power level differs from power phase");

    // A processed item never leaves the power timer due
    a_power_not_due: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> !(power_armed_reg && power_countdown_reg == '0))
        else $error("power timer left due after an item");

    // USB identification carries no profile slot
    a_usb_slot: assert property (@(posedge clk) disable iff (!rst_n)
        usb_identifying_reg |-> identify_slot_reg == SLOT_NONE)
        else $error("profile slot set during USB identification");

    // Indicator state changes only when an item moves to the result
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable({mute_level_reg, micmute_level_reg, profile_mask_reg,
                              power_countdown_reg, identify_left_reg}))
        else $error("state changed without an item");

    // A new result comes only from an item that moved forward
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("result appeared without an item");
`endif

endmodule

>>> sim/led_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_checker
// Watches the event, LED and register channels of the indicator controller.
// Keeps its own copy of the timers, identify state and durations, works out
// the LED levels that each accepted item must produce and compares them,
// field by field and in order, with the results the block hands out.
// ----------------------------------------------------------------------------
module led_checker
    import slbc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    slbc_evt_if    evt,
    slbc_led_if    led,
    slbc_cfg_if    cfg,
    output int     failures,
    output int     queued_results,
    output int     checked
);

    typedef struct packed {
        logic      power;
        logic      mute;
        logic      micmute;
        led_mask_t profile;
    } led_levels_t;

    // Durations as last written
    logic [CFG_DATA_W-1:0] dur_ident;
    logic [CFG_DATA_W-1:0] dur_usb_ident;
    logic [CFG_DATA_W-1:0] dur_pair;
    logic [CFG_DATA_W-1:0] dur_recon_on;
    logic [CFG_DATA_W-1:0] dur_recon_off;

    // Predicted controller state
    logic   use_radio;
    logic   pwr_phase;
    logic   pwr_armed;
    logic   pwr_on;
    timer_t pwr_left;
    logic   prof_phase;
    logic   usb_ident;
    logic   prof_armed;
    timer_t prof_left;
    timer_t ident_ms_left;
    slot_t  ident_idx;
    led_mask_t prof_lit;
    logic   mute_on;
    logic   mic_on;

    led_levels_t expected_levels[$];

    // Limit a written duration to what a countdown can hold
    function automatic timer_t saturate_ms(logic [CFG_DATA_W-1:0] v);
        if (64'(v) > ((64'd1 << TIMER_BITS) - 64'd1))
        begin
            return '1;
        end
        return timer_t'(v);
    endfunction

    // One LED per existing profile; the none slot and missing LEDs stay dark
    function automatic led_mask_t slot_mask(slot_t s);
        led_mask_t m;
        m = '0;
        if (s != SLOT_NONE && int'(s) < PROFILE_COUNT)
        begin
            m[s] = 1'b1;
        end
        return m;
    endfunction

    function automatic led_mask_t every_led();
        led_mask_t m;
        m = '0;
        for (int i = 0; i < LED_W; i++)
        begin
            m = m | slot_mask(slot_t'(i));
        end
        return m;
    endfunction

    function automatic void restart_power();
        pwr_phase = 1'b0;
        pwr_armed = 1'b1;
        pwr_left  = '0;
    endfunction

    function automatic void restart_profile(logic identify, slot_t active);
        prof_phase    = 1'b0;
        usb_ident     = 1'b0;
        ident_ms_left = identify ? saturate_ms(dur_ident) : '0;
        ident_idx     = identify ? active : SLOT_NONE;
        prof_armed    = 1'b1;
        prof_left     = '0;
    endfunction

    // Power timer expired: hold steady when the link is up, else blink
    function automatic void power_timer_due(logic hid, logic conn, logic open);
        logic   lit_next;
        timer_t wait_ms;
        pwr_armed = 1'b0;
        if ((!use_radio && hid) || (use_radio && conn))
        begin
            pwr_on    = 1'b1;
            pwr_phase = 1'b1;
        end
        else
        begin
            lit_next = !pwr_phase;
            if (!use_radio)
            begin
                wait_ms = lit_next ? USB_WAIT_ON_MS : USB_WAIT_OFF_MS;
            end
            else if (open)
            begin
                wait_ms = OPEN_HALF_MS;
            end
            else
            begin
                wait_ms = lit_next ? BONDED_ON_MS : BONDED_OFF_MS;
            end
            pwr_phase = lit_next;
            pwr_on    = lit_next;
            pwr_armed = 1'b1;
            pwr_left  = wait_ms;
        end
    endfunction

    // Profile timer expired: identify first, then pairing or reconnect blink
    function automatic void profile_timer_due(logic conn, logic open, slot_t active);
        prof_armed = 1'b0;
        if (ident_ms_left != '0)
        begin
            prof_lit   = (!use_radio && usb_ident) ? every_led() : slot_mask(ident_idx);
            prof_armed = 1'b1;
            prof_left  = ident_ms_left;
        end
        else if (!use_radio || conn)
        begin
            prof_lit = '0;
        end
        else
        begin
            prof_phase = !prof_phase;
            prof_lit   = prof_phase ? slot_mask(active) : '0;
            prof_armed = 1'b1;
            if (open)
            begin
                prof_left = saturate_ms(dur_pair);
            end
            else
            begin
                prof_left = saturate_ms(prof_phase ? dur_recon_on : dur_recon_off);
            end
        end
    endfunction

    // Advance the state by one item and return the LED levels it leaves
    function automatic led_levels_t step_indicators(evt_item_t it);
        led_levels_t r;
        case (it.operation)
            OP_TICK:
            begin
                if (pwr_armed && pwr_left != '0)
                begin
                    pwr_left = pwr_left - timer_t'(1);
                end
                if (prof_armed && prof_left != '0)
                begin
                    prof_left = prof_left - timer_t'(1);
                end
                if (ident_ms_left != '0)
                begin
                    ident_ms_left = ident_ms_left - timer_t'(1);
                end
            end
            OP_KEY:
            begin
                if (it.key_kind == KEY_MUTE)
                begin
                    mute_on = !mute_on;
                end
                else if (it.key_kind == KEY_MICMUTE)
                begin
                    mic_on = !mic_on;
                end
            end
            OP_USB_CHANGE:
            begin
                restart_power();
            end
            OP_PROFILE_CMD:
            begin
                use_radio = it.command_ble;
                restart_power();
                prof_phase = 1'b0;
                if (it.command_kind == CMD_USB)
                begin
                    usb_ident     = 1'b1;
                    use_radio     = 1'b0;
                    ident_idx     = SLOT_NONE;
                    ident_ms_left = saturate_ms(dur_usb_ident);
                end
                else
                begin
                    usb_ident = 1'b0;
                    ident_idx = it.command_profile;
                    if (it.command_kind == CMD_SELECT && !it.command_profile_open)
                    begin
                        ident_ms_left = saturate_ms(dur_ident);
                    end
                    else
                    begin
                        ident_ms_left = '0;
                    end
                end
                prof_armed = 1'b1;
                prof_left  = '0;
            end
            OP_PROFILE_CHANGED:
            begin
                restart_power();
                restart_profile(1'b0, it.active_profile);
            end
            OP_ENDPOINT_CHANGED:
            begin
                restart_power();
                if (it.endpoint_ble)
                begin
                    restart_profile(1'b1, it.active_profile);
                end
            end
            default:
            begin
            end
        endcase

        if (pwr_armed && pwr_left == '0)
        begin
            power_timer_due(it.usb_hid_ready, it.active_connected, it.active_open);
        end
        if (prof_armed && prof_left == '0)
        begin
            profile_timer_due(it.active_connected, it.active_open, it.active_profile);
        end

        r.power   = pwr_on;
        r.mute    = mute_on;
        r.micmute = mic_on;
        r.profile = prof_lit;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        failures++;
        $display("[%0t] result %0d: %s", $realtime, checked, what);
    endtask

    // Track writes, predict each item and compare each result in order
    always @(posedge clk or negedge rst_n)
    begin : watch
        evt_item_t   it;
        led_levels_t seen;
        led_levels_t want;
        if (!rst_n)
        begin
            dur_ident     = RST_PROFILE_IDENTIFY;
            dur_usb_ident = RST_USB_IDENTIFY;
            dur_pair      = RST_PAIRING_BLINK;
            dur_recon_on  = RST_RECONNECT_ON;
            dur_recon_off = RST_RECONNECT_OFF;
            use_radio     = 1'b0;
            pwr_phase     = 1'b0;
            pwr_armed     = 1'b1;
            pwr_on        = 1'b0;
            pwr_left      = '0;
            prof_phase    = 1'b0;
            usb_ident     = 1'b0;
            prof_armed    = 1'b0;
            prof_left     = '0;
            ident_ms_left = '0;
            ident_idx     = SLOT_NONE;
            prof_lit      = '0;
            mute_on       = 1'b0;
            mic_on        = 1'b0;
            expected_levels.delete();
            failures      = 0;
            checked       = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_PROFILE_IDENTIFY: dur_ident     = cfg.data;
                    REG_USB_IDENTIFY:     dur_usb_ident = cfg.data;
                    REG_PAIRING_BLINK:    dur_pair      = cfg.data;
                    REG_RECONNECT_ON:     dur_recon_on  = cfg.data;
                    REG_RECONNECT_OFF:    dur_recon_off = cfg.data;
                    default:
                    begin
                    end
                endcase
            end

            if (led.valid && led.ready)
            begin
                seen.power   = led.power_ind;
                seen.mute    = led.mute_ind;
                seen.micmute = led.mic_mute_ind;
                seen.profile = led.profile_ind;
                if (expected_levels.size() == 0)
                begin
                    report_mismatch("result with no item waiting for it");
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (seen.power !== want.power)
                    begin
                        report_mismatch($sformatf("power_ind got %b want %b",
                                                  seen.power, want.power));
                    end
                    if (seen.mute !== want.mute)
                    begin
                        report_mismatch($sformatf("mute_ind got %b want %b",
                                                  seen.mute, want.mute));
                    end
                    if (seen.micmute !== want.micmute)
                    begin
                        report_mismatch($sformatf("mic_mute_ind got %b want %b",
                                                  seen.micmute, want.micmute));
                    end
                    if (seen.profile !== want.profile)
                    begin
                        report_mismatch($sformatf("profile_ind got %b want %b",
                                                  seen.profile, want.profile));
                    end
                end
                checked++;
            end

            if (evt.valid && evt.ready)
            begin
                it.operation            = evt.operation;
                it.usb_hid_ready        = evt.usb_hid_ready;
                it.active_connected     = evt.active_connected;
                it.active_open          = evt.active_open;
                it.active_profile       = evt.active_profile;
                it.key_kind             = evt.key_kind;
                it.command_kind         = evt.command_kind;
                it.command_ble          = evt.command_ble;
                it.command_profile      = evt.command_profile;
                it.command_profile_open = evt.command_profile_open;
                it.endpoint_ble         = evt.endpoint_ble;
                expected_levels.push_back(step_indicators(it));
            end
        end
        queued_results = expected_levels.size();
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the status LED blink controller. Sends a short
// directed set of events, then single events each followed by a run of 1 ms
// ticks under several duration settings, with random gaps on both sides
// and long result stalls; the checker beside the block compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import slbc_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;
    localparam logic [1:0] KEY_PLAIN  = 2'd0;
    localparam logic [1:0] KEY_SPARE  = 2'd3;
    localparam logic [1:0] CMD_OTHER  = 2'd2;
    localparam logic [1:0] CMD_SPARE  = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int IDLE_PCT      = 23;
    localparam int HOLD_CYCLES   = 60;
    localparam int HOLD_AT_FIRST = 300;
    localparam int HOLD_AT_LATER = 1200;

    logic clk;
    logic rst_n;

    slbc_evt_if evt_ch ();
    slbc_led_if led_ch ();
    slbc_cfg_if cfg_ch ();

    int   mismatches;
    int   results_pending;
    int   results_checked;
    int   results_seen;
    int   hold_left;
    int   items_sent;
    int   settings_applied;
    logic quiet;

    // Link status held across a burst of items
    logic  link_hid;
    logic  link_conn;
    logic  link_open;
    slot_t link_active;

    status_led_blink_controller DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .led   (led_ch),
        .cfg   (cfg_ch)
    );

    led_checker CHK (
        .clk            (clk),
        .rst_n          (rst_n),
        .evt            (evt_ch),
        .led            (led_ch),
        .cfg            (cfg_ch),
        .failures       (mismatches),
        .queued_results (results_pending),
        .checked        (results_checked)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Result side: random stalls, plus long hold-offs so the block fills up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_ch.ready <= 1'b0;
            hold_left    <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (led_ch.valid && led_ch.ready)
            begin
                results_seen <= results_seen + 1;
            end
            if (hold_left != 0)
            begin
                led_ch.ready <= 1'b0;
                hold_left    <= hold_left - 1;
            end
            else if (led_ch.valid && led_ch.ready &&
                     (results_seen + 1 == HOLD_AT_FIRST || results_seen + 1 == HOLD_AT_LATER))
            begin
                led_ch.ready <= 1'b0;
                hold_left    <= HOLD_CYCLES;
            end
            else if (!quiet && $urandom_range(0, 99) < IDLE_PCT)
            begin
                led_ch.ready <= 1'b0;
            end
            else
            begin
                led_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one item, idling first at random, and return once it is taken
    task automatic push_event(input evt_item_t it);
        logic taken;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            evt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        evt_ch.valid                <= 1'b1;
        evt_ch.operation            <= it.operation;
        evt_ch.usb_hid_ready        <= it.usb_hid_ready;
        evt_ch.active_connected     <= it.active_connected;
        evt_ch.active_open          <= it.active_open;
        evt_ch.active_profile       <= it.active_profile;
        evt_ch.key_kind             <= it.key_kind;
        evt_ch.command_kind         <= it.command_kind;
        evt_ch.command_ble          <= it.command_ble;
        evt_ch.command_profile      <= it.command_profile;
        evt_ch.command_profile_open <= it.command_profile_open;
        evt_ch.endpoint_ble         <= it.endpoint_ble;
        do
        begin
            @(negedge clk);
            taken = evt_ch.ready;
            @(posedge clk);
        end
        while (!taken);
        items_sent++;
    endtask

    task automatic push_fields(input logic [2:0] op, input logic hid, input logic conn,
                               input logic open, input slot_t active, input logic [1:0] key,
                               input logic [1:0] cmd, input logic cble, input slot_t cprof,
                               input logic copen, input logic eble);
        evt_item_t it;
        it.operation            = op;
        it.usb_hid_ready        = hid;
        it.active_connected     = conn;
        it.active_open          = open;
        it.active_profile       = active;
        it.key_kind             = key;
        it.command_kind         = cmd;
        it.command_ble          = cble;
        it.command_profile      = cprof;
        it.command_profile_open = copen;
        it.endpoint_ble         = eble;
        push_event(it);
    endtask

    function automatic logic [2:0] pick_event_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return OP_KEY;
        if (r < 30) return OP_USB_CHANGE;
        if (r < 60) return OP_PROFILE_CMD;
        if (r < 70) return OP_PROFILE_CHANGED;
        if (r < 88) return OP_ENDPOINT_CHANGED;
        if (r < 92) return OP_SPARE_A;
        if (r < 96) return OP_SPARE_B;
        return OP_TICK;
    endfunction

    function automatic logic [1:0] pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return CMD_SELECT;
        if (r < 70) return CMD_USB;
        if (r < 88) return CMD_OTHER;
        return CMD_SPARE;
    endfunction

    // Item with the held link status, now and then with noise on it
    function automatic evt_item_t fresh_item(input logic [2:0] op);
        evt_item_t it;
        it.operation            = op;
        it.usb_hid_ready        = ($urandom_range(0, 9) == 0) ? 1'($urandom) : link_hid;
        it.active_connected     = ($urandom_range(0, 9) == 0) ? 1'($urandom) : link_conn;
        it.active_open          = ($urandom_range(0, 9) == 0) ? 1'($urandom) : link_open;
        it.active_profile       = link_active;
        it.key_kind             = 2'($urandom_range(0, 3));
        it.command_kind         = pick_command();
        it.command_ble          = ($urandom_range(0, 3) != 0);
        it.command_profile      = 2'($urandom_range(0, 3));
        it.command_profile_open = 1'($urandom);
        it.endpoint_ble         = ($urandom_range(0, 3) != 0);
        return it;
    endfunction

    // Events each followed by a run of ticks, the link moving now and then
    task automatic run_traffic(input int count);
        int n;
        int burst;
        int k;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                link_hid    = 1'($urandom);
                link_conn   = ($urandom_range(0, 2) == 0);
                link_open   = 1'($urandom);
                link_active = ($urandom_range(0, 7) == 0) ? SLOT_NONE : slot_t'($urandom_range(0, 2));
            end
            push_event(fresh_item(pick_event_op()));
            n++;
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 260) : $urandom_range(1, 25);
            for (k = 0; k < burst && n < count; k++)
            begin
                push_event(fresh_item(OP_TICK));
                n++;
            end
        end
    endtask

    // Drop the item valid and wait until every result is back
    task automatic wait_drained();
        evt_ch.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (results_pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        logic taken;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
        begin
            @(negedge clk);
            taken = cfg_ch.ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Load all five durations while the block is idle
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] ident, input logic [CFG_DATA_W-1:0] usb,
                                  input logic [CFG_DATA_W-1:0] pair, input logic [CFG_DATA_W-1:0] on_ms,
                                  input logic [CFG_DATA_W-1:0] off_ms, input logic spare);
        wait_drained();
        write_reg(REG_PROFILE_IDENTIFY, ident);
        write_reg(REG_USB_IDENTIFY, usb);
        write_reg(REG_PAIRING_BLINK, pair);
        write_reg(REG_RECONNECT_ON, on_ms);
        write_reg(REG_RECONNECT_OFF, off_ms);
        if (spare)
        begin
            write_reg(REG_SPARE_LO, 16'($urandom));
            write_reg(REG_SPARE_HI, 16'($urandom));
        end
        cfg_ch.valid <= 1'b0;
        settings_applied++;
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        quiet        <= 1'b0;
        evt_ch.valid <= 1'b0;
        evt_ch.operation            <= OP_TICK;
        evt_ch.usb_hid_ready        <= 1'b0;
        evt_ch.active_connected     <= 1'b0;
        evt_ch.active_open          <= 1'b0;
        evt_ch.active_profile       <= '0;
        evt_ch.key_kind             <= KEY_PLAIN;
        evt_ch.command_kind         <= CMD_USB;
        evt_ch.command_ble          <= 1'b0;
        evt_ch.command_profile      <= '0;
        evt_ch.command_profile_open <= 1'b0;
        evt_ch.endpoint_ble         <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_PROFILE_IDENTIFY;
        cfg_ch.data  <= '0;
        items_sent       = 0;
        settings_applied = 0;
        link_hid    = 1'b0;
        link_conn   = 1'b0;
        link_open   = 1'b0;
        link_active = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: keys, spare codes, every command kind, none slot, endpoints
        push_fields(OP_TICK, 0, 0, 0, 2'd0, KEY_PLAIN, CMD_USB, 0, 2'd0, 0, 0);
        push_fields(OP_KEY, 0, 0, 0, 2'd0, KEY_MUTE, CMD_USB, 0, 2'd0, 0, 0);
        push_fields(OP_KEY, 0, 0, 0, 2'd0, KEY_MICMUTE, CMD_USB, 0, 2'd0, 0, 0);
        push_fields(OP_KEY, 0, 0, 0, 2'd0, KEY_PLAIN, CMD_USB, 0, 2'd0, 0, 0);
        push_fields(OP_KEY, 1, 1, 1, SLOT_NONE, KEY_SPARE, CMD_SPARE, 1, SLOT_NONE, 1, 1);
        push_fields(OP_SPARE_A, 0, 0, 0, 2'd0, KEY_MUTE, CMD_USB, 0, 2'd0, 0, 0);
        push_fields(OP_SPARE_B, 1, 1, 1, SLOT_NONE, KEY_SPARE, CMD_SPARE, 1, SLOT_NONE, 1, 1);
        push_fields(OP_USB_CHANGE, 1, 0, 0, 2'd0, KEY_PLAIN, CMD_USB, 0, 2'd0, 0, 0);
        push_fields(OP_PROFILE_CMD, 1, 0, 0, 2'd0, KEY_PLAIN, CMD_USB, 1, 2'd1, 0, 0);
        push_fields(OP_TICK, 1, 0, 0, 2'd0, KEY_PLAIN, CMD_USB, 0, 2'd0, 0, 0);
        push_fields(OP_PROFILE_CMD, 0, 0, 0, 2'd1, KEY_PLAIN, CMD_SELECT, 1, 2'd1, 0, 0);
        push_fields(OP_PROFILE_CMD, 0, 0, 0, 2'd1, KEY_PLAIN, CMD_SELECT, 1, SLOT_NONE, 0, 0);
        push_fields(OP_PROFILE_CMD, 0, 0, 1, 2'd2, KEY_PLAIN, CMD_SELECT, 1, 2'd2, 1, 0);
        push_fields(OP_PROFILE_CMD, 0, 0, 0, 2'd2, KEY_PLAIN, CMD_OTHER, 1, 2'd2, 0, 0);
        push_fields(OP_PROFILE_CMD, 0, 1, 0, 2'd0, KEY_PLAIN, CMD_SPARE, 0, 2'd0, 0, 0);
        push_fields(OP_PROFILE_CHANGED, 0, 0, 1, SLOT_NONE, KEY_PLAIN, CMD_USB, 0, 2'd0, 0, 0);
        push_fields(OP_PROFILE_CMD, 0, 0, 1, 2'd0, KEY_PLAIN, CMD_SELECT, 1, 2'd0, 1, 0);
        push_fields(OP_ENDPOINT_CHANGED, 0, 0, 0, 2'd2, KEY_PLAIN, CMD_USB, 0, 2'd0, 0, 1);
        push_fields(OP_ENDPOINT_CHANGED, 0, 0, 0, SLOT_NONE, KEY_PLAIN, CMD_USB, 0, 2'd0, 0, 1);
        push_fields(OP_ENDPOINT_CHANGED, 0, 1, 0, 2'd1, KEY_PLAIN, CMD_USB, 0, 2'd0, 0, 0);
        push_fields(OP_PROFILE_CHANGED, 0, 0, 1, 2'd1, KEY_PLAIN, CMD_USB, 0, 2'd0, 0, 0);
        push_fields(OP_TICK, 1, 1, 1, SLOT_NONE, KEY_SPARE, CMD_SPARE, 1, SLOT_NONE, 1, 1);
        run_traffic(150);

        // Short durations so identify and blink phases turn over quickly
        apply_settings(16'd4, 16'd3, 16'd2, 16'd1, 16'd3, 1'b0);
        run_traffic(500);

        // Lowest durations: no identify, blink on every tick
        apply_settings(16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 1'b1);
        push_fields(OP_PROFILE_CMD, 0, 0, 0, 2'd1, KEY_PLAIN, CMD_USB, 0, 2'd1, 0, 0);
        push_fields(OP_TICK, 0, 0, 0, 2'd1, KEY_PLAIN, CMD_USB, 0, 2'd1, 0, 0);
        push_fields(OP_PROFILE_CMD, 0, 0, 0, 2'd1, KEY_PLAIN, CMD_SELECT, 1, 2'd1, 0, 0);
        push_fields(OP_TICK, 0, 0, 0, 2'd1, KEY_PLAIN, CMD_USB, 0, 2'd1, 0, 0);
        run_traffic(350);

        // Largest durations
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        run_traffic(150);

        // Random moderate durations, opening with a stretch without idling
        apply_settings(16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
                       16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                       16'($urandom_range(1, 12)), 1'b0);
        quiet <= 1'b1;
        run_traffic(300);
        quiet <= 1'b0;
        run_traffic(250);

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Run covered %0d items and %0d results under %0d duration settings,",
                 items_sent, results_checked, settings_applied + 1);
        $display("with long result stalls and runs with and without random gaps.");
        if (mismatches == 0)
        begin
            $display("PASS status_led_blink_controller");
        end
        else
        begin
            $display("FAIL status_led_blink_controller");
        end
        $finish;
    end

    // Give up long after the slowest correct run would have ended
    initial
    begin
        #5000000;
        $display("FAIL status_led_blink_controller");
        $finish;
    end

endmodule

>>> files.f
rtl/core/slbc_pkg.sv
rtl/core/slbc_if.sv
rtl/core/status_led_blink_controller.sv
sim/led_checker.sv
sim/testbench.sv
